### hdl/icdf_pkg.sv
// Package for the inverse transform sampler: shared widths, types and
// configuration register indexes. No dependencies.
package icdf_pkg;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = 43;
    localparam int CNT_W      = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT   = 2'd3;

    typedef logic [31:0]               t_word;
    typedef logic signed [31:0]        t_sword;
    typedef logic [47:0]               t_var;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]     t_cfg_data;
endpackage

### hdl/inverse_cdf_sampler_with_variance.sv
// Inverse transform sampler over a piecewise-linear table, with group mean and variance.
// Depends on icdf_pkg; one shared subtractor serves division and square root.
//
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   mode, point_index, point_x, point_density,
//                                                point_cdf, uniform
// out       output     o_out_valid / i_out_ready sample_value, group_last, group_mean,
//                                                group_variance
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A load is written to the tables while the sequencer stays idle. A draw first runs a
// binary search of floor(log2(P))+1 steps over the P table points; in continuous mode
// the 64-step divider runs at most twice and the 32-step square root at most once in a
// sloped interval. A draw that closes a group adds two divisions, for mean and variance.
// Reset is synchronous and active low; the tables are not cleared.
// The input is ready only while the sequencer is idle; a finished result waits in
// the output register while the next request is taken.
module inverse_cdf_sampler_with_variance #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_GROUP   = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic [7:0]          i_point_index,
    input  icdf_pkg::t_sword    i_point_x,
    input  icdf_pkg::t_word     i_point_density,
    input  icdf_pkg::t_word     i_point_cdf,
    input  icdf_pkg::t_word     i_uniform,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output icdf_pkg::t_sword    o_sample_value,
    output logic                o_group_last,
    output icdf_pkg::t_sword    o_group_mean,
    output icdf_pkg::t_var      o_group_variance,
    input  logic                i_cfg_we,
    input  icdf_pkg::t_cfg_idx  i_cfg_idx,
    input  icdf_pkg::t_cfg_data i_cfg_data
);
    import icdf_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int PW  = $clog2(TABLE_DEPTH + 1);
    localparam int CW  = (PW > 9) ? PW : 9;
    localparam int IXW = (AW > 8) ? AW : 8;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SRCH = 5'd1;
    localparam logic [4:0] ST_SCMP = 5'd2;
    localparam logic [4:0] ST_FET0 = 5'd3;
    localparam logic [4:0] ST_FET1 = 5'd4;
    localparam logic [4:0] ST_FET2 = 5'd5;
    localparam logic [4:0] ST_SLP  = 5'd6;
    localparam logic [4:0] ST_SQ   = 5'd7;
    localparam logic [4:0] ST_RAD  = 5'd8;
    localparam logic [4:0] ST_DEN  = 5'd9;
    localparam logic [4:0] ST_TQ   = 5'd10;
    localparam logic [4:0] ST_FIN  = 5'd11;
    localparam logic [4:0] ST_ACC  = 5'd12;
    localparam logic [4:0] ST_ACC2 = 5'd13;
    localparam logic [4:0] ST_MEAN = 5'd14;
    localparam logic [4:0] ST_MSQ  = 5'd15;
    localparam logic [4:0] ST_VAR  = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;
    localparam logic [4:0] ST_DIV  = 5'd18;
    localparam logic [4:0] ST_SQRT = 5'd19;
    localparam logic [4:0] ST_MUL  = 5'd20;

    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    t_word mem_pos [TABLE_DEPTH];
    t_word mem_den [TABLE_DEPTH];
    t_word mem_cdf [TABLE_DEPTH];

    logic [4:0]        r_state, r_after;
    logic              r_kind;
    logic [CNT_W-1:0]  r_spg;
    logic [8:0]        r_piu;
    logic [15:0]       r_lim;
    t_word             r_u;
    logic [PW-1:0]     r_lo, r_hi, r_mid, r_p;
    logic [AW-1:0]     r_idx;
    t_word             r_pos_q, r_den_q, r_cdf_q;
    t_word             r_x0, r_y0, r_a;
    logic [32:0]       r_dx;
    logic              r_dy_neg;
    t_word             r_mag;
    logic [63:0]       r_sq;
    logic [32:0]       r_t;
    t_word             r_x;
    logic signed [SUM_W-1:0] r_sum;
    logic [63:0]       r_sqsum;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_sum_neg, r_last;
    t_word             r_mean;
    logic [63:0]       r_msq;
    t_var              r_var;
    logic [63:0]       r_dvd;
    logic [32:0]       r_dvs, r_rem;
    logic [5:0]        r_it;
    logic [63:0]       r_num, r_res, r_bit;
    t_word             r_ma, r_mb;
    logic [63:0]       r_prod;
    logic              r_ovalid, r_olast;
    t_word             r_osample, r_omean;
    t_var              r_ovar;

    logic [PW-1:0]     n_p, w_mid, w_idx;
    logic [PW:0]       w_mid_sum;
    logic [CW-1:0]     w_piu_ext;
    logic [CNT_W-1:0]  n_grp;
    logic [AW-1:0]     w_rd_addr, w_wr_addr;
    logic [IXW-1:0]    w_ix_ext;
    logic              w_wr_ok, w_in_acc;
    logic [64:0]       w_diff;
    logic [63:0]       w_sub_a, w_sub_b;
    logic [33:0]       w_rem_sh;
    logic [32:0]       w_dx, w_dy, w_dy_negv, w_den;
    t_word             w_dy_mag, w_mag;
    logic [63:0]       w_term, w_rad, w_esq, w_vfull;
    logic [64:0]       w_rad_sum;
    logic [63:0]       w_sqsum_new;
    logic signed [SUM_W-1:0] w_sum_new;
    logic [SUM_W-1:0]  w_sum_mag;
    logic [CNT_W-1:0]  w_cnt_new;
    logic [32:0]       w_mmag;
    logic [33:0]       w_fin;
    t_word             w_xmag;

    assign o_in_ready       = (r_state == ST_IDLE);
    assign w_in_acc         = i_in_valid && o_in_ready;
    assign o_out_valid      = r_ovalid;
    assign o_sample_value   = r_osample;
    assign o_group_last     = r_olast;
    assign o_group_mean     = r_omean;
    assign o_group_variance = r_ovar;

    always_comb begin
        w_piu_ext = CW'(r_piu);
        if (w_piu_ext < CW'(2)) begin
            n_p = PW'(2);
        end else if (w_piu_ext > CW'(TABLE_DEPTH)) begin
            n_p = PW'(TABLE_DEPTH);
        end else begin
            n_p = w_piu_ext[PW-1:0];
        end
        if (r_spg == '0) begin
            n_grp = CNT_W'(1);
        end else if (32'(r_spg) > MAX_GROUP) begin
            n_grp = CNT_W'(MAX_GROUP);
        end else begin
            n_grp = r_spg;
        end
        w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
        w_mid     = w_mid_sum[PW:1];
        w_idx     = (r_lo >= r_p) ? (r_p - PW'(1)) : r_lo;
        if (!r_kind && w_idx == '0) begin
            w_idx = PW'(1);
        end
        w_ix_ext  = IXW'(i_point_index);
        w_wr_addr = w_ix_ext[AW-1:0];
        w_wr_ok   = (32'(i_point_index) < TABLE_DEPTH);
        case (r_state)
            ST_SRCH: w_rd_addr = w_mid[AW-1:0];
            ST_FET0: w_rd_addr = r_kind ? r_idx : (r_idx - AW'(1));
            default: w_rd_addr = r_idx;
        endcase
    end

    always_comb begin
        w_rem_sh = {r_rem, r_dvd[63]};
        if (r_state == ST_SQRT) begin
            w_sub_a = r_num;
            w_sub_b = r_res + r_bit;
        end else begin
            w_sub_a = 64'(w_rem_sh);
            w_sub_b = 64'(r_dvs);
        end
        w_diff = {1'b0, w_sub_a} - {1'b0, w_sub_b};

        w_dx      = {r_pos_q[31], r_pos_q} - {r_x0[31], r_x0};
        w_dy      = {1'b0, r_den_q} - {1'b0, r_y0};
        w_dy_negv = -w_dy;
        w_dy_mag  = w_dy[32] ? w_dy_negv[31:0] : w_dy[31:0];

        if (!r_dy_neg) begin
            w_mag = (r_dvd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_dvd[31:0];
        end else begin
            w_mag = (r_dvd > 64'h8000_0000) ? 32'h8000_0000 : r_dvd[31:0];
        end

        w_term    = {15'd0, r_prod[63:15]};
        w_rad_sum = {1'b0, r_sq} + {1'b0, w_term};
        if (r_dy_neg) begin
            w_rad = (r_sq >= w_term) ? (r_sq - w_term) : 64'd0;
        end else begin
            w_rad = w_rad_sum[64] ? {64{1'b1}} : w_rad_sum[63:0];
        end
        w_den = {1'b0, r_y0} + {1'b0, r_res[31:0]};

        w_fin  = {{2{r_x0[31]}}, r_x0} + {1'b0, r_t};
        w_xmag = r_x[31] ? (32'd0 - r_x) : r_x;

        w_sqsum_new = r_sqsum + {16'd0, r_prod[63:16]};
        w_sum_new   = r_sum + SUM_W'($signed(r_x));
        w_sum_mag   = w_sum_new[SUM_W-1] ? SUM_W'(-w_sum_new) : SUM_W'(w_sum_new);
        w_cnt_new   = r_cnt + CNT_W'(1);

        w_mmag  = r_dvd[32:0] + {32'd0, (r_sum_neg && r_rem != '0)};
        w_esq   = r_dvd;
        w_vfull = (w_esq > r_msq) ? (w_esq - r_msq) : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !i_mode && w_wr_ok) begin
            mem_pos[w_wr_addr] <= i_point_x;
            mem_den[w_wr_addr] <= i_point_density;
            mem_cdf[w_wr_addr] <= i_point_cdf;
        end
        r_pos_q <= mem_pos[w_rd_addr];
        r_den_q <= mem_den[w_rd_addr];
        r_cdf_q <= mem_cdf[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_after  <= ST_IDLE;
            r_kind   <= 1'b0;
            r_spg    <= CNT_W'(10);
            r_piu    <= 9'd2;
            r_lim    <= 16'd1;
            r_sum    <= '0;
            r_sqsum  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KIND:   r_kind <= i_cfg_data[0];
                    CFG_GROUP: begin
                        r_spg   <= i_cfg_data[CNT_W-1:0];
                        r_sum   <= '0;
                        r_sqsum <= '0;
                        r_cnt   <= '0;
                    end
                    CFG_POINTS: r_piu <= i_cfg_data[8:0];
                    CFG_FLAT:   r_lim <= i_cfg_data;
                    default:    r_lim <= r_lim;
                endcase
            end
            if (r_ovalid && i_out_ready && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && i_mode) begin
                        r_u     <= i_uniform;
                        r_lo    <= '0;
                        r_hi    <= n_p;
                        r_p     <= n_p;
                        r_state <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= ST_SCMP;
                    end else begin
                        r_idx   <= w_idx[AW-1:0];
                        r_state <= ST_FET0;
                    end
                end
                ST_SCMP: begin
                    if (r_cdf_q < r_u) begin
                        r_lo <= r_mid + PW'(1);
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= ST_SRCH;
                end
                ST_FET0: r_state <= ST_FET1;
                ST_FET1: begin
                    if (r_kind) begin
                        r_x     <= r_pos_q;
                        r_state <= ST_ACC;
                    end else begin
                        r_x0    <= r_pos_q;
                        r_y0    <= r_den_q;
                        r_a     <= (r_u >= r_cdf_q) ? (r_u - r_cdf_q) : 32'd0;
                        r_state <= ST_FET2;
                    end
                end
                ST_FET2: begin
                    if (w_dx[32] || w_dx == '0) begin
                        r_x     <= r_x0;
                        r_state <= ST_ACC;
                    end else begin
                        r_dx     <= w_dx;
                        r_dy_neg <= w_dy[32];
                        r_dvd    <= {16'd0, w_dy_mag, 16'd0};
                        r_dvs    <= w_dx;
                        r_rem    <= '0;
                        r_it     <= '0;
                        r_after  <= ST_SLP;
                        r_state  <= ST_DIV;
                    end
                end
                ST_SLP: begin
                    if (w_mag <= {16'd0, r_lim}) begin
                        if (r_y0 == '0) begin
                            r_t     <= r_dx;
                            r_state <= ST_FIN;
                        end else begin
                            r_dvd   <= {32'd0, r_a};
                            r_dvs   <= {1'b0, r_y0};
                            r_rem   <= '0;
                            r_it    <= '0;
                            r_after <= ST_TQ;
                            r_state <= ST_DIV;
                        end
                    end else begin
                        r_mag   <= w_mag;
                        r_ma    <= r_y0;
                        r_mb    <= r_y0;
                        r_after <= ST_SQ;
                        r_state <= ST_MUL;
                    end
                end
                ST_SQ: begin
                    r_sq    <= r_prod;
                    r_ma    <= r_mag;
                    r_mb    <= r_a;
                    r_after <= ST_RAD;
                    r_state <= ST_MUL;
                end
                ST_RAD: begin
                    r_num   <= w_rad;
                    r_res   <= '0;
                    r_bit   <= 64'h4000_0000_0000_0000;
                    r_it    <= '0;
                    r_after <= ST_DEN;
                    r_state <= ST_SQRT;
                end
                ST_DEN: begin
                    if (w_den == '0) begin
                        r_t     <= (r_a == '0) ? 33'd0 : r_dx;
                        r_state <= ST_FIN;
                    end else begin
                        r_dvd   <= {31'd0, r_a, 1'b0};
                        r_dvs   <= w_den;
                        r_rem   <= '0;
                        r_it    <= '0;
                        r_after <= ST_TQ;
                        r_state <= ST_DIV;
                    end
                end
                ST_TQ: begin
                    r_t     <= (r_dvd > {31'd0, r_dx}) ? r_dx : r_dvd[32:0];
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_x     <= w_fin[31:0];
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_ma    <= w_xmag;
                    r_mb    <= w_xmag;
                    r_after <= ST_ACC2;
                    r_state <= ST_MUL;
                end
                ST_ACC2: begin
                    r_sum   <= w_sum_new;
                    r_sqsum <= w_sqsum_new;
                    r_cnt   <= w_cnt_new;
                    if (w_cnt_new >= n_grp) begin
                        r_last    <= 1'b1;
                        r_sum_neg <= w_sum_new[SUM_W-1];
                        r_dvd     <= 64'(w_sum_mag);
                        r_dvs     <= 33'(w_cnt_new);
                        r_rem     <= '0;
                        r_it      <= '0;
                        r_after   <= ST_MEAN;
                        r_state   <= ST_DIV;
                    end else begin
                        r_last  <= 1'b0;
                        r_state <= ST_OUT;
                    end
                end
                ST_MEAN: begin
                    r_mean  <= r_sum_neg ? (32'd0 - w_mmag[31:0]) : w_mmag[31:0];
                    r_ma    <= w_mmag[31:0];
                    r_mb    <= w_mmag[31:0];
                    r_after <= ST_MSQ;
                    r_state <= ST_MUL;
                end
                ST_MSQ: begin
                    r_msq   <= {16'd0, r_prod[63:16]};
                    r_dvd   <= r_sqsum;
                    r_dvs   <= 33'(r_cnt);
                    r_rem   <= '0;
                    r_it    <= '0;
                    r_after <= ST_VAR;
                    r_state <= ST_DIV;
                end
                ST_VAR: begin
                    r_var   <= (w_vfull[63:48] != '0) ? {48{1'b1}} : w_vfull[47:0];
                    r_sum   <= '0;
                    r_sqsum <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid  <= 1'b1;
                        r_osample <= r_x;
                        r_olast   <= r_last;
                        r_omean   <= r_last ? r_mean : 32'd0;
                        r_ovar    <= r_last ? r_var : '0;
                        r_state   <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (!w_diff[64]) begin
                        r_rem <= w_diff[32:0];
                        r_dvd <= {r_dvd[62:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh[32:0];
                        r_dvd <= {r_dvd[62:0], 1'b0};
                    end
                    r_it <= r_it + 6'd1;
                    if (r_it == DIV_LAST) begin
                        r_state <= r_after;
                    end
                end
                ST_SQRT: begin
                    if (!w_diff[64]) begin
                        r_num <= w_diff[63:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_it  <= r_it + 6'd1;
                    if (r_it == SQRT_LAST) begin
                        r_state <= r_after;
                    end
                end
                ST_MUL: begin
                    r_prod  <= 64'(r_ma) * 64'(r_mb);
                    r_state <= r_after;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

### hdl/icdf_chk.sv
// Port checker for the inverse transform sampler, bound to the top level.
// Depends on icdf_pkg for port types.
module icdf_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             i_mode,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input icdf_pkg::t_sword o_sample_value,
    input logic             o_group_last,
    input icdf_pkg::t_sword o_group_mean,
    input icdf_pkg::t_var   o_group_variance
);
    import icdf_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_mode |=> !o_in_ready)
        else $error("input still ready after a draw request");

    a_no_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_group_last |-> o_group_mean == '0 && o_group_variance == '0)
        else $error("group fields set without group end");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_sample_value))
        else $error("result changed while stalled");
endmodule

bind inverse_cdf_sampler_with_variance icdf_chk u_icdf_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_mode           (i_mode),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_sample_value   (o_sample_value),
    .o_group_last     (o_group_last),
    .o_group_mean     (o_group_mean),
    .o_group_variance (o_group_variance)
);

### bench/sampler_checker.sv
`timescale 1ns / 100ps
// Checker for the inverse transform sampler: watches the request, result and register
// channels, predicts every result and compares it field by field. Depends on icdf_pkg.
module sampler_checker
    import icdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  logic      mode,
    input  logic [7:0] point_index,
    input  t_sword    point_x,
    input  t_word     point_density,
    input  t_word     point_cdf,
    input  t_word     uniform,
    input  logic      out_valid,
    input  logic      out_ready,
    input  t_sword    sample_value,
    input  logic      group_last,
    input  t_sword    group_mean,
    input  t_var      group_variance,
    input  logic      cfg_we,
    input  t_cfg_idx  cfg_idx,
    input  t_cfg_data cfg_data,
    output int        errors,
    output int        pending
);
    localparam int DEPTH = 256;
    localparam int GROUP_MAX = 1024;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
        logic [31:0] mean;
        logic [47:0] variance;
    } t_draw_result;

    longint          positions [DEPTH];
    longint unsigned densities [DEPTH];
    longint unsigned cdfs [DEPTH];
    longint          sum_x;
    longint unsigned sum_sq;
    int unsigned     draws;
    logic            discrete;
    int unsigned     group_len;
    int unsigned     points;
    longint unsigned flat_limit;
    t_draw_result    expected_draws [$];

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint interval_sample(int unsigned i, longint unsigned u);
        longint          x0, dx, dy, s;
        longint unsigned y0, c0, a, mag, t, sq, term, rad, den;
        x0 = positions[i-1];
        dx = positions[i] - x0;
        y0 = densities[i-1];
        c0 = cdfs[i-1];
        a = (u >= c0) ? u - c0 : 0;
        if (dx <= 0) return x0;
        dy = longint'(densities[i]) - longint'(y0);
        s = (dy * 65536) / dx;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        mag = (s < 0) ? -s : s;
        if (mag <= flat_limit) begin
            t = (y0 == 0) ? longint'(dx) : a / y0;
        end else begin
            sq = y0 * y0;
            term = (mag * a) >> 15;
            if (s > 0) rad = (sq > ~64'd0 - term) ? ~64'd0 : sq + term;
            else rad = (sq >= term) ? sq - term : 0;
            den = y0 + isqrt(rad);
            if (den == 0) t = (a == 0) ? 0 : longint'(dx);
            else t = (2 * a) / den;
        end
        if (t > longint'(dx)) t = dx;
        return x0 + longint'(t);
    endfunction

    function automatic t_draw_result predict_draw(longint unsigned u);
        t_draw_result    r;
        int unsigned     p, n, lo, hi, mid, idx;
        longint          x, mean, nn;
        longint unsigned ax, msq, esq, v;
        p = points;
        if (p < 2) p = 2;
        if (p > DEPTH) p = DEPTH;
        lo = 0;
        hi = p;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (cdfs[mid] < u) lo = mid + 1;
            else hi = mid;
        end
        idx = (lo >= p) ? p - 1 : lo;
        if (discrete) begin
            x = positions[idx];
        end else begin
            if (idx < 1) idx = 1;
            x = interval_sample(idx, u);
        end
        ax = (x < 0) ? -x : x;
        sum_x += x;
        sum_sq += (ax * ax) >> 16;
        draws++;
        n = group_len;
        if (n < 1) n = 1;
        if (n > GROUP_MAX) n = GROUP_MAX;
        r = '0;
        r.sample = x[31:0];
        if (draws >= n) begin
            nn = draws;
            mean = (sum_x >= 0) ? sum_x / nn : -((-sum_x + nn - 1) / nn);
            ax = (mean < 0) ? -mean : mean;
            msq = (ax * ax) >> 16;
            esq = sum_sq / nn;
            v = (esq > msq) ? esq - msq : 0;
            if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
            r.last = 1'b1;
            r.mean = mean[31:0];
            r.variance = v[47:0];
            sum_x = 0;
            sum_sq = 0;
            draws = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, field, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        t_draw_result want;
        if (!rst_n) begin
            sum_x = 0;
            sum_sq = 0;
            draws = 0;
            discrete = 1'b0;
            group_len = 10;
            points = 2;
            flat_limit = 1;
            errors = 0;
            expected_draws.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (expected_draws.size() == 0) begin
                    report_mismatch("unexpected result", sample_value, 0);
                end else begin
                    want = expected_draws.pop_front();
                    if (sample_value !== want.sample)
                        report_mismatch("sample_value", sample_value, want.sample);
                    if (group_last !== want.last)
                        report_mismatch("group_last", group_last, want.last);
                    if (group_mean !== want.mean)
                        report_mismatch("group_mean", group_mean, want.mean);
                    if (group_variance !== want.variance)
                        report_mismatch("group_variance", group_variance, want.variance);
                end
            end
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_KIND: discrete = cfg_data[0];
                    CFG_GROUP: begin
                        group_len = cfg_data[10:0];
                        sum_x = 0;
                        sum_sq = 0;
                        draws = 0;
                    end
                    CFG_POINTS: points = cfg_data[8:0];
                    CFG_FLAT: flat_limit = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                if (!mode) begin
                    positions[point_index] = longint'(point_x);
                    densities[point_index] = point_density;
                    cdfs[point_index] = point_cdf;
                end else begin
                    expected_draws.push_back(predict_draw(uniform));
                end
            end
        end
        pending = expected_draws.size();
    end
endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Top of the sampler testbench: clock, reset, table loads, draws and register phases.
// Depends on icdf_pkg, the sampler RTL and sampler_checker.
module testbench;
    import icdf_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 400;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    logic      i_mode = 1'b0;
    logic [7:0] i_point_index = '0;
    t_sword    i_point_x = '0;
    t_word     i_point_density = '0;
    t_word     i_point_cdf = '0;
    t_word     i_uniform = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_sword    o_sample_value;
    logic      o_group_last;
    t_sword    o_group_mean;
    t_var      o_group_variance;
    logic      i_cfg_we = 1'b0;
    t_cfg_idx  i_cfg_idx = CFG_KIND;
    t_cfg_data i_cfg_data = '0;

    int        errors;
    int        pending;
    int        send_idle = 0;
    int        recv_stall = 0;
    int        idle_cycles = 0;
    t_word     table_cdf [256];

    always #4 i_clk = ~i_clk;

    inverse_cdf_sampler_with_variance i_dut (.*);

    sampler_checker i_checker (
        .clk(i_clk), .rst_n(i_rst_n), .in_valid(i_in_valid), .in_ready(o_in_ready),
        .mode(i_mode), .point_index(i_point_index), .point_x(i_point_x),
        .point_density(i_point_density), .point_cdf(i_point_cdf), .uniform(i_uniform),
        .out_valid(o_out_valid), .out_ready(i_out_ready), .sample_value(o_sample_value),
        .group_last(o_group_last), .group_mean(o_group_mean),
        .group_variance(o_group_variance), .cfg_we(i_cfg_we), .cfg_idx(i_cfg_idx),
        .cfg_data(i_cfg_data), .errors(errors), .pending(pending)
    );

    always @(negedge i_clk) i_out_ready <= ($urandom_range(0, 99) >= recv_stall);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(logic m, logic [7:0] idx, t_sword x, t_word d, t_word c, t_word u);
        logic taken;
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_point_index <= idx;
        i_point_x <= x;
        i_point_density <= d;
        i_point_cdf <= c;
        i_uniform <= u;
        do begin
            @(posedge i_clk);
            taken = o_in_ready;
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic load_point(logic [7:0] idx, t_sword x, t_word d, t_word c);
        send(1'b0, idx, x, d, c, $urandom);
    endtask

    task automatic draw(t_word u);
        send(1'b1, $urandom, $urandom, $urandom, $urandom, u);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[15:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Sorted table with random content; some intervals are empty or reversed.
    task automatic fill_table(int peff);
        longint cur, step, step_max;
        longint unsigned spacing;
        t_word   d, c;
        cur = -64'sd2147483648 + $urandom_range(0, 1 << 28);
        step_max = (64'sd4026531838) / peff;
        spacing = 64'hFFFF_FFFF / peff;
        for (int k = 0; k < peff; k++) begin
            case ($urandom_range(0, 7))
                0: d = 0;
                1: d = 32'hFFFF_FFFF;
                default: d = $urandom;
            endcase
            c = k * spacing + $urandom_range(0, spacing - 1);
            if (k == peff - 1 && $urandom_range(0, 1)) c = 32'hFFFF_FFFF;
            table_cdf[k] = c;
            load_point(k, cur[31:0], d, c);
            step = ($urandom_range(0, 7) == 0) ? -longint'($urandom_range(0, 1000))
                                                : longint'($urandom_range(1, step_max));
            if (cur + step < -64'sd2147483648) step = 0;
            cur += step;
        end
    endtask

    task automatic run_phase(logic kind, int unsigned group_len, int unsigned points,
                             int unsigned flat, int items, int idle_mode);
        int   peff;
        t_word u;
        write_reg(CFG_KIND, kind);
        write_reg(CFG_GROUP, group_len);
        write_reg(CFG_POINTS, points);
        write_reg(CFG_FLAT, flat);
        peff = (points < 2) ? 2 : (points > 256) ? 256 : points;
        case (idle_mode)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 49; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 49; end
            default: begin send_idle = 26; recv_stall = 26; end
        endcase
        fill_table(peff);
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(0, 99) < 15) begin
                load_point($urandom_range(0, 1) ? $urandom_range(0, peff - 1) : $urandom,
                           $urandom, $urandom, $urandom);
            end else begin
                case ($urandom_range(0, 9))
                    0: u = 0;
                    1: u = 32'hFFFF_FFFF;
                    2: u = table_cdf[$urandom_range(0, peff - 1)];
                    default: u = $urandom;
                endcase
                draw(u);
            end
        end
        settle();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Short directed pass: boundary fractions, extreme point values, both modes.
        write_reg(CFG_KIND, 0);
        write_reg(CFG_GROUP, 1);
        write_reg(CFG_POINTS, 2);
        write_reg(CFG_FLAT, 0);
        fill_table(4);
        draw(0);
        draw(32'hFFFF_FFFF);
        draw(table_cdf[1]);
        draw(table_cdf[0]);
        load_point(2, 32'sh8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        load_point(3, 32'sh7FFF_FFFF, 0, 0);
        load_point(1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        draw(32'h8000_0000);
        draw(0);
        load_point(0, 32'sh8000_0000, 0, 0);
        draw(32'h0000_0001);
        load_point(1, 32'sh8000_0000, 0, 32'hFFFF_FFFF);
        draw(32'h7FFF_FFFF);
        settle();
        write_reg(CFG_KIND, 1);
        draw(0);
        draw(32'hFFFF_FFFF);
        settle();

        run_phase(0, 10, 16, 0, 220, 0);
        run_phase(1, 0, 0, 65535, 200, 1);
        run_phase(0, 7, 256, 100, 260, 2);
        run_phase(1, 1024, 511, 0, 260, 3);
        run_phase(0, 2047, 5, 65535, 200, 0);
        run_phase(0, 3, 1, 2000, 220, 1);
        run_phase(1, 5, 37, 5, 200, 2);
        run_phase(0, 1, 3, 1, 220, 3);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
